FILE: src/swt_pkg.sv
// shared types and constants of the sentence and word tokenizer
`default_nettype none

package swt_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned EvNum  = 5;

  typedef logic [CountW-1:0] count_t;
  typedef logic [ByteW-1:0]  byte_t;

  // blanks end a word
  localparam byte_t ChSpace = 8'h20;
  localparam byte_t ChTab   = 8'h09;
  localparam byte_t ChCr    = 8'h0D;
  // line breaks end a sentence
  localparam byte_t ChVt    = 8'h0B;
  localparam byte_t ChLf    = 8'h0A;
  localparam byte_t ChFf    = 8'h0C;

  typedef enum logic [1:0] {
    MODE_BETWEEN_SENTENCES = 2'd0,
    MODE_BETWEEN_WORDS     = 2'd1,
    MODE_IN_WORD           = 2'd2,
    MODE_ENDED             = 2'd3
  } scan_mode_e;

  typedef enum logic [2:0] {
    EV_WORD_BYTE      = 3'd0,
    EV_WORD_END       = 3'd1,
    EV_SENTENCE_START = 3'd2,
    EV_SENTENCE_END   = 3'd3,
    EV_END_OF_STREAM  = 3'd4
  } ev_kind_e;

  // set of events caused by one item, one mask bit per event kind
  typedef struct packed {
    logic [EvNum-1:0] mask;
    byte_t            ch;
    count_t           prev;
    count_t           after;
  } ev_set_t;

endpackage

`default_nettype wire

FILE: src/swt_classify.sv
// byte classification and scan mode update for one item
`default_nettype none

module swt_classify (
  input  swt_pkg::scan_mode_e mode_i,
  input  swt_pkg::count_t     count_i,
  input  swt_pkg::byte_t      text_byte_i,
  input  logic                end_of_input_i,
  output swt_pkg::ev_set_t    ev_o,
  output swt_pkg::scan_mode_e mode_o
);
  import swt_pkg::*;

  logic is_blank;
  logic is_break;

  assign is_blank = (text_byte_i == ChSpace) || (text_byte_i == ChTab) ||
                    (text_byte_i == ChCr);
  assign is_break = (text_byte_i == ChVt) || (text_byte_i == ChLf) ||
                    (text_byte_i == ChFf);

  always_comb begin
    ev_o.mask  = '0;
    ev_o.ch    = text_byte_i;
    ev_o.prev  = count_i;
    ev_o.after = count_i + count_t'(1);
    mode_o     = mode_i;
    if (mode_i == MODE_ENDED) begin
      // nothing is counted once the stream has ended
      ev_o.after = count_i;
      if (end_of_input_i) begin
        ev_o.mask[EV_END_OF_STREAM] = 1'b1;
      end
    end else if (end_of_input_i || is_break) begin
      if (mode_i == MODE_IN_WORD) begin
        ev_o.mask[EV_WORD_END] = 1'b1;
      end
      if (mode_i != MODE_BETWEEN_SENTENCES) begin
        ev_o.mask[EV_SENTENCE_END] = 1'b1;
      end
      if (end_of_input_i) begin
        ev_o.mask[EV_END_OF_STREAM] = 1'b1;
        mode_o = MODE_ENDED;
      end else begin
        mode_o = MODE_BETWEEN_SENTENCES;
      end
    end else if (is_blank) begin
      if (mode_i == MODE_IN_WORD) begin
        ev_o.mask[EV_WORD_END] = 1'b1;
        mode_o = MODE_BETWEEN_WORDS;
      end
    end else begin
      if (mode_i == MODE_BETWEEN_SENTENCES) begin
        ev_o.mask[EV_SENTENCE_START] = 1'b1;
      end
      ev_o.mask[EV_WORD_BYTE] = 1'b1;
      mode_o = MODE_IN_WORD;
    end
  end

endmodule

`default_nettype wire

FILE: src/swt_burst.sv
// pending event register and output register, one event out per cycle while the receiver does not stall
`default_nettype none

module swt_burst (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  swt_pkg::ev_set_t  ev_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output swt_pkg::ev_kind_e event_kind_o,
  output swt_pkg::byte_t    word_char_o,
  output swt_pkg::count_t   byte_count_o,
  output logic              last_event_o
);
  import swt_pkg::*;

  logic [EvNum-1:0] mask_q, mask_d;
  byte_t            ch_q;
  count_t           prev_q;
  count_t           after_q;

  logic             out_valid_q;
  ev_kind_e         kind_q;
  byte_t            char_q;
  count_t           count_q;
  logic             last_q;

  logic             out_free;
  logic             has_pend;
  ev_kind_e         sel_kind;
  logic [EvNum-1:0] sel_bit;
  logic [EvNum-1:0] rest;

  assign out_free = !out_valid_q || !out_stall_i;
  assign has_pend = |mask_q;

  // fixed emission order: sentence start, word byte, word end, sentence end, end of stream
  always_comb begin
    if (mask_q[EV_SENTENCE_START]) begin
      sel_kind = EV_SENTENCE_START;
    end else if (mask_q[EV_WORD_BYTE]) begin
      sel_kind = EV_WORD_BYTE;
    end else if (mask_q[EV_WORD_END]) begin
      sel_kind = EV_WORD_END;
    end else if (mask_q[EV_SENTENCE_END]) begin
      sel_kind = EV_SENTENCE_END;
    end else begin
      sel_kind = EV_END_OF_STREAM;
    end
    sel_bit           = '0;
    sel_bit[sel_kind] = 1'b1;
  end

  assign rest    = mask_q & ~sel_bit;
  assign ready_o = !has_pend || (out_free && (rest == '0));

  always_comb begin
    mask_d = mask_q;
    if (out_free && has_pend) begin
      mask_d = rest;
    end
    if (load_i) begin
      mask_d = ev_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (out_free) begin
        out_valid_q <= has_pend;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ch_q    <= ev_i.ch;
      prev_q  <= ev_i.prev;
      after_q <= ev_i.after;
    end
    if (out_free && has_pend) begin
      kind_q  <= sel_kind;
      char_q  <= (sel_kind == EV_WORD_BYTE) ? ch_q : '0;
      count_q <= (sel_kind == EV_SENTENCE_START) ? prev_q : after_q;
      last_q  <= (rest == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign word_char_o  = char_q;
  assign byte_count_o = count_q;
  assign last_event_o = last_q;

endmodule

`default_nettype wire

FILE: src/sentence_word_tokenizer_core.sv
// top level of the sentence and word tokenizer
//
// input channel: one item per handshake, a text byte or an end-of-input
// marker; accepted at a rising edge with in_valid_i high and in_stall_o low.
// output channel: one event per handshake (kind, word byte, byte count,
// last-of-item flag); taken at a rising edge with out_valid_o high and
// out_stall_i low.
// an accepted item is loaded into the pending register; its first event then
// moves on into the output register, which drives the outputs, as soon as
// that register is free.
// throughput: one item per cycle while every item causes at most one event
// and the receiver does not stall; an item causing several events keeps the
// input stalled until its last event moves into the single output register,
// which takes one event per cycle while the receiver does not stall.
// configuration: a write on cfg_wr_en_i loads the position counter with
// cfg_wr_data_i; write only while the block is idle.
// reset: scan mode goes to between sentences, position counter to zero,
// nothing pending and no output valid.
// when the receiver stalls, the output item holds, the remaining events
// of the item wait in the pending register and the input stalls once that
// register cannot take a new item.
`default_nettype none

module sentence_word_tokenizer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_wr_en_i,
  input  swt_pkg::count_t   cfg_wr_data_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  swt_pkg::byte_t    text_byte_i,
  input  logic              end_of_input_i,
  // output events
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output swt_pkg::ev_kind_e event_kind_o,
  output swt_pkg::byte_t    word_char_o,
  output swt_pkg::count_t   byte_count_o,
  output logic              last_event_o
);
  import swt_pkg::*;

  scan_mode_e mode_q, mode_d;
  count_t     pos_q, pos_d;

  ev_set_t    ev;
  scan_mode_e mode_next;
  logic       burst_ready;
  logic       in_acc;

  // classify the incoming item against the current scan state
  swt_classify u_classify (
    .mode_i         (mode_q),
    .count_i        (pos_q),
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .ev_o           (ev),
    .mode_o         (mode_next)
  );

  assign in_stall_o = !burst_ready;
  assign in_acc     = in_valid_i && burst_ready;

  // scan mode and position update on every accepted item; the position freezes once the stream has ended
  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    if (in_acc) begin
      mode_d = mode_next;
      pos_d  = ev.after;
    end
    // a register write preloads the counter
    if (cfg_wr_en_i) begin
      pos_d = cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BETWEEN_SENTENCES;
      pos_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
    end
  end

  // events of the item are held and sent out one per cycle while the receiver does not stall
  swt_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_acc),
    .ev_i         (ev),
    .ready_o      (burst_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .word_char_o  (word_char_o),
    .byte_count_o (byte_count_o),
    .last_event_o (last_event_o)
  );

  // a burst of events goes out without gaps
  a_burst_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_event_o |=> out_valid_o)
    else $error("event burst broken by a gap");

  // only word byte events carry a character
  a_char_only_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != EV_WORD_BYTE) |-> (word_char_o == '0))
    else $error("character on a non word byte event");

  // sentence start is always followed by the word byte of the same item
  a_start_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_SENTENCE_START) |-> !last_event_o)
    else $error("sentence start marked as last event");

  // no counting after the stream has ended
  a_ended_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode_q == MODE_ENDED) && !cfg_wr_en_i |=> (pos_q == $past(pos_q)))
    else $error("position moved after end of stream");

endmodule

`default_nettype wire

FILE: dv/swt_event_checker.sv
// event predictor and checker for the sentence and word tokenizer
`default_nettype none

module swt_event_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  swt_pkg::count_t   cfg_wr_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  swt_pkg::byte_t    text_byte_i,
  input  logic              end_of_input_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  swt_pkg::ev_kind_e event_kind_i,
  input  swt_pkg::byte_t    word_char_i,
  input  swt_pkg::count_t   byte_count_i,
  input  logic              last_event_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);
  import swt_pkg::*;

  typedef struct packed {
    ev_kind_e kind;
    byte_t    ch;
    count_t   count;
    logic     last;
  } token_event_t;

  token_event_t expected_events[$];
  scan_mode_e   scan_mode;
  count_t       position;
  int unsigned  mismatches;

  task automatic add_event(input ev_kind_e kind, input byte_t ch, input count_t count);
    token_event_t ev;
    ev.kind  = kind;
    ev.ch    = ch;
    ev.count = count;
    ev.last  = 1'b0;
    expected_events = {expected_events, ev};
  endtask

  // events one item causes, in order, with the mode and position update
  task automatic tokenize_item(input byte_t b, input logic fin);
    count_t      before_cnt;
    int unsigned first;
    logic        is_break;
    logic        is_blank;
    before_cnt = position;
    first      = expected_events.size();
    is_break   = (b == ChVt) || (b == ChLf) || (b == ChFf);
    is_blank   = (b == ChSpace) || (b == ChTab) || (b == ChCr);
    if (scan_mode == MODE_ENDED) begin
      // stream over: bytes vanish, end markers repeat the frozen count
      if (fin) add_event(EV_END_OF_STREAM, '0, position);
    end else begin
      position = position + 1'b1;
      if (fin || is_break) begin
        if (scan_mode == MODE_IN_WORD) add_event(EV_WORD_END, '0, position);
        if (scan_mode != MODE_BETWEEN_SENTENCES) add_event(EV_SENTENCE_END, '0, position);
        if (fin) begin
          add_event(EV_END_OF_STREAM, '0, position);
          scan_mode = MODE_ENDED;
        end else begin
          scan_mode = MODE_BETWEEN_SENTENCES;
        end
      end else if (is_blank) begin
        if (scan_mode == MODE_IN_WORD) begin
          add_event(EV_WORD_END, '0, position);
          scan_mode = MODE_BETWEEN_WORDS;
        end
      end else begin
        // sentence_start carries the count before this byte
        if (scan_mode == MODE_BETWEEN_SENTENCES) add_event(EV_SENTENCE_START, '0, before_cnt);
        add_event(EV_WORD_BYTE, b, position);
        scan_mode = MODE_IN_WORD;
      end
    end
    if (expected_events.size() > first)
      expected_events[expected_events.size() - 1].last = 1'b1;
  endtask

  task automatic check_event();
    token_event_t ev;
    if (expected_events.size() == 0) begin
      $error("unexpected event: kind %0d, word_char %0h, byte_count %0h, last_event %0b",
             event_kind_i, word_char_i, byte_count_i, last_event_i);
      mismatches++;
    end else begin
      ev = expected_events.pop_front();
      if (event_kind_i !== ev.kind) begin
        $error("event_kind: expected %0d, actual %0d", ev.kind, event_kind_i);
        mismatches++;
      end
      if (word_char_i !== ev.ch) begin
        $error("word_char: expected %0h, actual %0h", ev.ch, word_char_i);
        mismatches++;
      end
      if (byte_count_i !== ev.count) begin
        $error("byte_count: expected %0h, actual %0h", ev.count, byte_count_i);
        mismatches++;
      end
      if (last_event_i !== ev.last) begin
        $error("last_event: expected %0b, actual %0b", ev.last, last_event_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode  = MODE_BETWEEN_SENTENCES;
      position   = '0;
      mismatches = 0;
      expected_events.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_wr_en_i) position = cfg_wr_data_i;
      if (in_valid_i && !in_stall_i) tokenize_item(text_byte_i, end_of_input_i);
      if (out_valid_i && !out_stall_i) check_event();
      pending_o    <= expected_events.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// stimulus, receiver stalls and verdict for the sentence and word tokenizer
`default_nettype none

module testbench;
  import swt_pkg::*;

  // generous bound: ~190 items, up to three events each, heavy stalls and
  // one long receiver hold-off stay far below this
  localparam int unsigned CycleLimit = 200_000;
  // settle time after the drain, for items that cause no event
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned ItemsPerPhase = 45;

  logic clk;
  logic rst_n;

  // block inputs, all driven from time zero
  logic   cfg_wr_en;
  count_t cfg_wr_data;
  logic   in_valid;
  byte_t  text_byte;
  logic   end_of_input;
  logic   out_stall = 1'b1;

  // block outputs
  logic     in_stall;
  logic     out_valid;
  ev_kind_e event_kind;
  byte_t    word_char;
  count_t   byte_count;
  logic     last_event;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned items_sent;

  // idling knobs, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // long receiver hold-off, requested by the stimulus, counted by the stall driver
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  byte_t directed_text [22];
  int    end_case;

  sentence_word_tokenizer_core u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .text_byte_i    (text_byte),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_kind_o   (event_kind),
    .word_char_o    (word_char),
    .byte_count_o   (byte_count),
    .last_event_o   (last_event)
  );

  swt_event_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .text_byte_i    (text_byte),
    .end_of_input_i (end_of_input),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .event_kind_i   (event_kind),
    .word_char_i    (word_char),
    .byte_count_i   (byte_count),
    .last_event_i   (last_event),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run bound: a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off once it is requested
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldOffCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // any byte but the six separators
  function automatic byte_t pick_word_byte();
    byte_t b;
    do b = byte_t'($urandom_range(255));
    while (b inside {ChSpace, ChTab, ChCr, ChVt, ChLf, ChFf});
    return b;
  endfunction

  function automatic byte_t pick_blank();
    case ($urandom_range(2))
      0:       return ChSpace;
      1:       return ChTab;
      default: return ChCr;
    endcase
  endfunction

  function automatic byte_t pick_break();
    case ($urandom_range(2))
      0:       return ChVt;
      1:       return ChLf;
      default: return ChFf;
    endcase
  endfunction

  // offer one item and wait for it to be taken; valid stays high afterwards
  // so back-to-back items follow without a gap
  task automatic send_item(input byte_t b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    text_byte    <= b;
    end_of_input <= fin;
    do @(posedge clk);
    while (in_stall);
    items_sent++;
  endtask

  task automatic send_word();
    int unsigned len;
    len = $urandom_range(1, 6);
    repeat (len) send_item(pick_word_byte(), 1'b0);
  endtask

  // mostly well-formed sentences with random words, some raw noise bytes
  task automatic send_random_text(input int unsigned n_items);
    int unsigned target;
    int unsigned n_words;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 12) begin
        send_item(byte_t'($urandom_range(255)), 1'b0);
      end else begin
        // occasional leading blank between sentences
        if ($urandom_range(3) == 0) send_item(pick_blank(), 1'b0);
        n_words = $urandom_range(1, 4);
        for (int unsigned w = 0; w < n_words; w++) begin
          send_word();
          if (w + 1 < n_words || $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) send_item(pick_blank(), 1'b0);
          end
        end
        // a sentence break, sometimes doubled into a blank run
        repeat ($urandom_range(1, 2)) send_item(pick_break(), 1'b0);
      end
    end
  endtask

  // drain: drop valid, wait for every expected event, then let items
  // without events settle through the pipeline
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk);
    while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_start_position(input count_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    text_byte    = '0;
    end_of_input = 1'b0;
    items_sent   = 0;

    // directed text: NUL and 0xff as word bytes, blank runs inside a
    // sentence, line breaks between words, inside a word and between
    // sentences, blanks between sentences, alternating bit patterns
    directed_text = '{8'h00, 8'hFF, ChSpace, ChSpace, ChTab, 8'h41, ChCr, ChLf,
                      ChLf, ChFf, ChVt, ChSpace, 8'h7F, ChVt, 8'h80, ChFf,
                      8'hAA, ChSpace, 8'h55, ChTab, ChFf, ChCr};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: counter at the top so the first items wrap it,
    // sender rarely idles, receiver stalls most of the time
    write_start_position(32'hFFFF_FFFF);
    send_idle_pct  = 8;
    recv_stall_pct = 79;
    foreach (directed_text[i]) send_item(directed_text[i], 1'b0);
    send_random_text(ItemsPerPhase);
    wait_idle();

    // phase two: counter from zero, roles of the two sides swapped
    write_start_position('0);
    send_idle_pct  = 79;
    recv_stall_pct = 8;
    send_random_text(ItemsPerPhase);
    wait_idle();

    // phase three: random start, no idling; the receiver first holds off
    // long enough for the block to fill and stall its input
    write_start_position(count_t'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    send_random_text(ItemsPerPhase);

    // close the stream from a random mode: inside a word, between words
    // or between sentences
    end_case = $urandom_range(2);
    send_word();
    if (end_case == 1) send_item(pick_blank(), 1'b0);
    if (end_case == 2) send_item(pick_break(), 1'b0);
    send_item(byte_t'($urandom_range(255)), 1'b1);
    // after the end: bytes are dropped, a second marker repeats the end event
    send_item(8'hFF, 1'b0);
    send_item(pick_word_byte(), 1'b0);
    send_item(byte_t'($urandom_range(255)), 1'b1);
    wait_idle();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sentence_word_tokenizer_core.f
src/swt_pkg.sv
src/swt_classify.sv
src/swt_burst.sv
src/sentence_word_tokenizer_core.sv
dv/swt_event_checker.sv
dv/testbench.sv
